>>> src/mrw_pkg.sv
// ----------------------------------------------------------------------------
// mrw_pkg
// Shared types for the witness round: controller commands and datapath status.
// ----------------------------------------------------------------------------
package mrw_pkg;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,     // capture operands, start a mod reduce of the base
    OP_SHIFT,    // one step of the split of n-1 into d*2^s
    OP_MUL_ACC,  // acc <= acc*base mod n
    OP_MUL_SQB,  // base <= base*base mod n
    OP_MUL_SQX,  // acc <= acc*acc mod n
    OP_EXP_STEP  // e >>= 1
  } op_t;

  typedef struct packed {
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic busy;     // multiplier or reducer running
    logic n_lt2;
    logic n_eq2;
    logic d_odd;
    logic e_zero;
    logic e_lsb;
    logic acc_one;
    logic acc_nm1;
    logic s_gt1;
  } stat_t;

endpackage

>>> src/mrw_datapath.sv
// ----------------------------------------------------------------------------
// mrw_datapath
// Operand registers and a shared shift-add modular multiplier, one bit of the
// multiplier operand per cycle. The base reduction mod n is a restoring
// bit-serial remainder with its own subtractor rather than the adder.
// ----------------------------------------------------------------------------
module mrw_datapath import mrw_pkg::*; #(
  parameter int NUM_WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [NUM_WIDTH-1:0] n_in,
  input  logic [NUM_WIDTH-1:0] a_in,
  input  cmd_t                 cmd,
  output stat_t                stat
);
  localparam int CW = $clog2(NUM_WIDTH + 1);

  logic [NUM_WIDTH-1:0] n, nm1, base, acc, e, mop, mul_b, red_a;
  logic [CW-1:0]        s, cnt;
  logic                 running, reducing;
  logic [1:0]           dest;   // 0 acc, 1 base

  localparam logic [1:0] DST_ACC = 2'd0;
  localparam logic [1:0] DST_BASE = 2'd1;

  // (x + y) mod n for x, y < n
  function automatic logic [NUM_WIDTH-1:0] addm(input logic [NUM_WIDTH-1:0] x,
      input logic [NUM_WIDTH-1:0] y, input logic [NUM_WIDTH-1:0] m);
    logic [NUM_WIDTH-1:0] gap;
    gap = m - y;
    return (x >= gap) ? x - gap : x + y;
  endfunction

  logic [NUM_WIDTH-1:0] dbl, step;
  logic [NUM_WIDTH:0]   rem_sh;
  assign dbl    = addm(acc, acc, n);
  assign step   = mul_b[NUM_WIDTH-1] ? addm(dbl, mop, n) : dbl;
  // remainder step: shift in next bit of the base
  assign rem_sh = {base, red_a[NUM_WIDTH-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      reducing <= 1'b0;
    end else if (reducing) begin
      base  <= (rem_sh >= {1'b0, n}) ? NUM_WIDTH'(rem_sh - {1'b0, n})
                                       : rem_sh[NUM_WIDTH-1:0];
      red_a <= red_a << 1;
      cnt   <= cnt - 1'b1;
      if (cnt == CW'(1)) reducing <= 1'b0;
    end else if (running) begin
      // a base squaring ends with acc restored from its parked copy
      acc   <= (cnt == CW'(1) && dest == DST_BASE) ? red_a : step;
      mul_b <= mul_b << 1;
      cnt   <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        running <= 1'b0;
        if (dest == DST_BASE) base <= step;
      end
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          n        <= n_in;
          nm1      <= n_in - 1'b1;
          e        <= n_in - 1'b1;
          s        <= '0;
          base     <= '0;
          red_a    <= a_in;
          cnt      <= CW'(NUM_WIDTH);
          reducing <= 1'b1;
          acc      <= NUM_WIDTH'(1);
        end
        OP_SHIFT: begin
          e <= e >> 1;
          s <= s + 1'b1;
        end
        OP_MUL_ACC: begin
          mop <= base; mul_b <= acc; acc <= '0; dest <= DST_ACC;
          cnt <= CW'(NUM_WIDTH); running <= 1'b1;
        end
        OP_MUL_SQB: begin
          // park acc in red_a
          red_a <= acc;
          mop <= base; mul_b <= base; acc <= '0; dest <= DST_BASE;
          cnt <= CW'(NUM_WIDTH); running <= 1'b1;
        end
        OP_MUL_SQX: begin
          mop <= acc; mul_b <= acc; acc <= '0; dest <= DST_ACC;
          cnt <= CW'(NUM_WIDTH); running <= 1'b1;
          s <= s - 1'b1;
        end
        OP_EXP_STEP: e <= e >> 1;
        default: ;
      endcase
    end
  end

  assign stat.busy    = running | reducing;
  assign stat.n_lt2   = (n < NUM_WIDTH'(2));
  assign stat.n_eq2   = (n == NUM_WIDTH'(2));
  assign stat.d_odd   = e[0];
  assign stat.e_zero  = (e == '0);
  assign stat.e_lsb   = e[0];
  assign stat.acc_one = (acc == NUM_WIDTH'(1));
  assign stat.acc_nm1 = (acc == nm1);
  assign stat.s_gt1   = (s > CW'(1));

  // Squaring of base finishes with acc restored from the parked copy.
  // (mop holds base during that multiply, so the copy lives in red_a.)

endmodule

>>> src/mrw_ctrl.sv
// ----------------------------------------------------------------------------
// mrw_ctrl
// Sequencer of the round: check n below 3, split n-1, square-and-multiply, then the squarings.
// ----------------------------------------------------------------------------
module mrw_ctrl import mrw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  done,
  output logic  pass
);
  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_CHECK, S_SPLIT, S_EXP, S_EXP_MUL, S_EXP_SQ, S_EXP_SH,
    S_TEST, S_SQX, S_SQX_CHK, S_DONE
  } state_t;

  state_t state;

  always_comb begin
    cmd.op = OP_NONE;
    if (!stat.busy) begin
      case (state)
        S_SPLIT:   if (!stat.d_odd) cmd.op = OP_SHIFT;
        S_EXP_MUL: if (stat.e_lsb) cmd.op = OP_MUL_ACC;
        S_EXP_SQ:  cmd.op = OP_MUL_SQB;
        S_EXP_SH:  cmd.op = OP_EXP_STEP;
        S_SQX:     cmd.op = OP_MUL_SQX;
        default:   cmd.op = OP_NONE;
      endcase
    end
    if (state == S_IDLE && start) cmd.op = OP_LOAD;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
      pass  <= 1'b0;
    end else begin
      done <= !stat.busy && (state == S_DONE);
      if (!stat.busy) begin
        case (state)
          S_IDLE: if (start) begin
            state <= S_LOAD;
            busy  <= 1'b1;
          end
          S_LOAD: state <= S_CHECK;
          S_CHECK: begin
            if (stat.n_lt2 || stat.n_eq2) begin
              pass  <= stat.n_eq2;
              state <= S_DONE;
            end else begin
              state <= S_SPLIT;
            end
          end
          S_SPLIT:   if (stat.d_odd) state <= S_EXP;
          S_EXP:     state <= stat.e_zero ? S_TEST : S_EXP_MUL;
          S_EXP_MUL: state <= S_EXP_SQ;
          S_EXP_SQ:  state <= S_EXP_SH;
          S_EXP_SH:  state <= S_EXP;
          S_TEST: begin
            if (stat.acc_one || stat.acc_nm1) begin
              pass <= 1'b1; state <= S_DONE;
            end else if (!stat.s_gt1) begin
              pass <= 1'b0; state <= S_DONE;
            end else begin
              state <= S_SQX;
            end
          end
          S_SQX: state <= S_SQX_CHK;
          S_SQX_CHK: begin
            if (stat.acc_nm1) begin
              pass <= 1'b1; state <= S_DONE;
            end else if (stat.acc_one || !stat.s_gt1) begin
              pass <= 1'b0; state <= S_DONE;
            end else begin
              state <= S_SQX;
            end
          end
          S_DONE: begin
            busy  <= 1'b0;
            state <= S_IDLE;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("done outside idle");
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy with done");
  a_no_cmd_busy: assert property (@(posedge clk) disable iff (rst)
    stat.busy && state != S_IDLE |-> cmd.op == OP_NONE)
    else $error("command while unit busy");

endmodule

>>> src/miller_rabin_witness_round.sv
// ----------------------------------------------------------------------------
// miller_rabin_witness_round
// One Miller-Rabin round on a candidate for a given witness base.
// ----------------------------------------------------------------------------
//  channel  signals                          handshake
//  input    candidate, witness_base          start & !busy
//  result   probable_prime                   done, one cycle
//
// An item first reduces the base mod n bit-serially, then runs at most
// 2*NUM_WIDTH modular products (bit-serial shift-add multiplier, one
// operand bit per cycle), their number set by the length of d and by s.
// Candidates below 3 still wait for the reduction before their result.
// Reset clears the controller and the datapath run flags.
// Results cannot be stalled; busy falls in the cycle done is high.
// ----------------------------------------------------------------------------
module miller_rabin_witness_round import mrw_pkg::*; #(
  parameter int NUM_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] candidate,
  input  logic [63:0] witness_base,
  output logic        done,
  output logic        probable_prime
);
  cmd_t  cmd;
  stat_t stat;

  mrw_datapath #(.NUM_WIDTH(NUM_WIDTH)) u_dp (
    .clk  (clk),
    .rst  (rst),
    .n_in (candidate[NUM_WIDTH-1:0]),
    .a_in (witness_base[NUM_WIDTH-1:0]),
    .cmd  (cmd),
    .stat (stat)
  );

  mrw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done),
    .pass  (probable_prime)
  );

endmodule
